// ----- sv/disjoint_set_union_by_size_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the union-find engine, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_BY_SIZE_ASSERT_SVH
`define DISJOINT_SET_UNION_BY_SIZE_ASSERT_SVH

// Property checked out of reset only.
`define DSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define DSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dsu_pkg.sv -----
// ----------------------------------------------------------------------------
// dsu_pkg
// Widths, operation codes and the command and result structures shared by
// the union-find engine and its top level.
// ----------------------------------------------------------------------------
package dsu_pkg;

  // Field widths of the item ports.
  localparam int NODE_W = 10;
  localparam int SIZE_W = 11;
  localparam int CFG_W  = 11;

  // Default number of nodes held in the stores.
  localparam int NODES_DEF = 1024;

  // Node limit after reset, and the largest reportable set size.
  localparam logic [CFG_W-1:0]  CFG_RESET = 11'd1024;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = 11'h7FF;

  // Operation codes.
  localparam logic FUNC_MERGE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Command handed to the engine, with the range check already done.
  typedef struct packed {
    logic              func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              bad;
  } dsu_cmd_t;

  // Result of one operation.
  typedef struct packed {
    logic [NODE_W-1:0] root;
    logic [SIZE_W-1:0] comp_size;
    logic              merged;
    logic              error;
  } dsu_res_t;

endpackage

// ----- sv/dsu_if.sv -----
// ----------------------------------------------------------------------------
// dsu_if
// Valid/ready channels for operation requests and for their results.
// ----------------------------------------------------------------------------
interface dsu_in_if
  import dsu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, func, node_a, node_b, input ready);
  modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

interface dsu_out_if
  import dsu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] root;
  logic [SIZE_W-1:0] comp_size;
  logic              merged;
  logic              error;

  modport source (output valid, root, comp_size, merged, error, input ready);
  modport sink   (input valid, root, comp_size, merged, error, output ready);
endinterface

// ----- sv/dsu_engine.sv -----
// ----------------------------------------------------------------------------
// dsu_engine
// Sequencer that walks and compresses parent chains in the parent memory,
// then reads root sizes in the size memory to report a size or link two sets.
// ----------------------------------------------------------------------------
`include "disjoint_set_union_by_size_assert.svh"

module dsu_engine
  import dsu_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  dsu_cmd_t cmd,
  output logic     res_valid,
  input  logic     res_ready,
  output dsu_res_t res
);

  localparam int IW  = $clog2(NODES);
  localparam int SW  = $clog2(NODES + 1);
  localparam int SXW = (SW > SIZE_W) ? SW : SIZE_W;
  localparam logic [IW-1:0] CLR_LAST = IW'(NODES - 1);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_COMP   = 7'b0001000,
    S_SIZE_A = 7'b0010000,
    S_SIZE_B = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  // Clamp a stored size to the width of the result field.
  function automatic logic [SIZE_W-1:0] sat_size(input logic [SW-1:0] s);
    logic [SXW-1:0] e;
    begin
      e = SXW'(s);
      sat_size = (e > SXW'(SIZE_MAX)) ? SIZE_MAX : e[SIZE_W-1:0];
    end
  endfunction

  // Memories.
  logic [IW-1:0] par_mem [NODES];
  logic [SW-1:0] sz_mem  [NODES];
  logic          par_we, sz_we;
  logic [IW-1:0] par_waddr, par_wdata, par_raddr, sz_waddr, sz_raddr;
  logic [SW-1:0] sz_wdata;
  logic [IW-1:0] par_rd_r;
  logic [SW-1:0] sz_rd_r;

  // Sequencer registers.
  state_t        state_r, state_nxt;
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] start_r, start_nxt;
  logic [IW-1:0] root_r, root_nxt;
  logic [IW-1:0] ra_r, ra_nxt;
  logic [IW-1:0] rb_r, rb_nxt;
  logic [IW-1:0] b_r, b_nxt;
  logic          op_r, op_nxt;
  logic          second_r, second_nxt;
  logic [SW-1:0] sza_r, sza_nxt;
  dsu_res_t      res_r, res_nxt;

  // Find completion and the shared compare/add unit.
  logic          fin;
  logic [IW-1:0] fin_root;
  logic [IW-1:0] win;
  logic [SW-1:0] size_sum;
  logic          do_link;

  assign size_sum  = sza_r + sz_rd_r;
  assign do_link   = (op_r == FUNC_MERGE) && (ra_r != rb_r);
  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (sz_we) begin
      sz_mem[sz_waddr] <= sz_wdata;
    end
    par_rd_r <= par_mem[par_raddr];
    sz_rd_r  <= sz_mem[sz_raddr];
  end

  // Next-state and memory control.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cur_nxt     = cur_r;
    start_nxt   = start_r;
    root_nxt    = root_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    b_nxt       = b_r;
    op_nxt      = op_r;
    second_nxt  = second_r;
    sza_nxt     = sza_r;
    res_nxt     = res_r;
    par_we      = 1'b0;
    par_waddr   = cur_r;
    par_wdata   = root_r;
    par_raddr   = cur_r;
    sz_we       = 1'b0;
    sz_waddr    = ra_r;
    sz_wdata    = size_sum;
    sz_raddr    = ra_r;
    fin         = 1'b0;
    fin_root    = cur_r;
    win         = ra_r;

    unique case (state_r)
      // Sweep every node back to a singleton root.
      S_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_cnt_r;
        par_wdata = clr_cnt_r;
        sz_we     = 1'b1;
        sz_waddr  = clr_cnt_r;
        sz_wdata  = SW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + IW'(1);
        end
      end
      // Take a command; a rejected one answers at once.
      S_IDLE: begin
        if (cmd_valid) begin
          op_nxt = cmd.func;
          b_nxt  = IW'(cmd.node_b);
          if (cmd.bad) begin
            res_nxt.root      = '0;
            res_nxt.comp_size = '0;
            res_nxt.merged    = 1'b0;
            res_nxt.error     = 1'b1;
            state_nxt         = S_DONE;
          end else begin
            cur_nxt    = IW'(cmd.node_a);
            start_nxt  = IW'(cmd.node_a);
            second_nxt = 1'b0;
            par_raddr  = IW'(cmd.node_a);
            state_nxt  = S_WALK;
          end
        end
      end
      // Follow one parent link per cycle until a node points at itself.
      S_WALK: begin
        if (par_rd_r == cur_r) begin
          if (start_r == cur_r) begin
            fin      = 1'b1;
            fin_root = cur_r;
          end else begin
            root_nxt  = cur_r;
            cur_nxt   = start_r;
            par_raddr = start_r;
            state_nxt = S_COMP;
          end
        end else begin
          cur_nxt   = par_rd_r;
          par_raddr = par_rd_r;
        end
      end
      // Relink each node of the walked path straight to the root.
      S_COMP: begin
        par_we = 1'b1;
        if (par_rd_r == root_r) begin
          fin      = 1'b1;
          fin_root = root_r;
        end else begin
          cur_nxt   = par_rd_r;
          par_raddr = par_rd_r;
        end
      end
      // Size of the first root is in; either report it or fetch the second.
      S_SIZE_A: begin
        if (do_link) begin
          sza_nxt   = sz_rd_r;
          sz_raddr  = rb_r;
          state_nxt = S_SIZE_B;
        end else begin
          res_nxt.root      = NODE_W'(ra_r);
          res_nxt.comp_size = sat_size(sz_rd_r);
          res_nxt.merged    = 1'b0;
          res_nxt.error     = 1'b0;
          state_nxt         = S_DONE;
        end
      end
      // Link the smaller root under the larger; ties go to the first root.
      S_SIZE_B: begin
        par_we = 1'b1;
        sz_we  = 1'b1;
        if (sza_r >= sz_rd_r) begin
          par_waddr = rb_r;
          par_wdata = ra_r;
          sz_waddr  = ra_r;
          win       = ra_r;
        end else begin
          par_waddr = ra_r;
          par_wdata = rb_r;
          sz_waddr  = rb_r;
          win       = rb_r;
        end
        res_nxt.root      = NODE_W'(win);
        res_nxt.comp_size = sat_size(size_sum);
        res_nxt.merged    = 1'b1;
        res_nxt.error     = 1'b0;
        state_nxt         = S_DONE;
      end
      // Hold the result until the output side takes it.
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // A finished find either starts the second find or moves on to sizes.
    if (fin) begin
      if (!second_r) begin
        ra_nxt = fin_root;
        if (op_r == FUNC_QUERY) begin
          sz_raddr  = fin_root;
          state_nxt = S_SIZE_A;
        end else begin
          cur_nxt    = b_r;
          start_nxt  = b_r;
          second_nxt = 1'b1;
          par_raddr  = b_r;
          state_nxt  = S_WALK;
        end
      end else begin
        rb_nxt    = fin_root;
        sz_raddr  = ra_r;
        state_nxt = S_SIZE_A;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    start_r  <= start_nxt;
    root_r   <= root_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    b_r      <= b_nxt;
    op_r     <= op_nxt;
    second_r <= second_nxt;
    sza_r    <= sza_nxt;
    res_r    <= res_nxt;
  end

  // Checks.
  `DSU_ASSERT(a_comp_not_root, (state_r == S_COMP) |-> (cur_r != root_r), "compression rewrote the root")
  `DSU_ASSERT(a_link_distinct, (state_r == S_SIZE_B) |-> (ra_r != rb_r), "linking a root to itself")
  `DSU_ASSERT(a_bad_answers, (cmd_valid && cmd_ready && cmd.bad) |=> (res_valid && res_r.error), "rejected command not answered")
  `DSU_ASSERT(a_merge_ok, (res_valid && res_r.merged) |-> !res_r.error, "merge reported with error")
  `DSU_ASSERT(a_clear_step, (state_r == S_CLEAR && clr_cnt_r != CLR_LAST) |=> (clr_cnt_r == $past(clr_cnt_r) + IW'(1)), "clearing sweep skipped an entry")

endmodule

// ----- sv/disjoint_set_union_by_size.sv -----
// ----------------------------------------------------------------------------
// disjoint_set_union_by_size
// Union-find engine with union by size and path compression.
// ----------------------------------------------------------------------------
// After reset the block sweeps every entry of its parent and size memories
// (NODES, 1024 by default) and takes no operation until the sweep is done. It
// then works on one operation at a time, and the request channel is not ready
// in between. The parent memory has a single read port, so a find first walks
// up from the node one link at a time to its root, then goes down the same
// path again and relinks every node on it straight to the root. A query is
// one find followed by a read of the root's size, and its result then goes to
// the output register. A merge is two finds, then two size reads when the
// roots differ; it links the smaller root under the larger and adds the sizes.
// A rejected operation is answered straight from the request, with no find.
// The result sits in an output register, so a new operation is taken while
// the previous result waits for transfer; a stalled output holds the engine
// only once that register is full.
// ----------------------------------------------------------------------------
module disjoint_set_union_by_size
  import dsu_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  dsu_in_if.sink           in_chan,
  dsu_out_if.source        out_chan
);

  localparam int NODES_CLAMP = (NODES < 2048) ? NODES : 2047;

  logic [CFG_W-1:0] node_count_r;
  logic [CFG_W-1:0] lim;
  logic             a_bad, b_bad;
  dsu_cmd_t         cmd;
  logic             cmd_ready;
  logic             res_valid, res_ready;
  dsu_res_t         res;
  logic             out_valid_r;
  dsu_res_t         out_r;

  // Node limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CFG_RESET;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // Range check against the node limit, clamped to the store depth.
  assign lim   = (node_count_r > CFG_W'(NODES_CLAMP)) ? CFG_W'(NODES_CLAMP) : node_count_r;
  assign a_bad = (CFG_W'(in_chan.node_a) >= lim);
  assign b_bad = (CFG_W'(in_chan.node_b) >= lim);

  assign cmd.func   = in_chan.func;
  assign cmd.node_a = in_chan.node_a;
  assign cmd.node_b = in_chan.node_b;
  assign cmd.bad    = a_bad || ((in_chan.func == FUNC_MERGE) && b_bad);

  assign in_chan.ready = cmd_ready;

  dsu_engine #(
    .NODES (NODES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_chan.valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register between the engine and the result channel.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.root      = out_r.root;
  assign out_chan.comp_size = out_r.comp_size;
  assign out_chan.merged    = out_r.merged;
  assign out_chan.error     = out_r.error;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Union-find engine testbench
// Drives merge and query operations into the engine's request channel and
// checks each result against a predictor of union by size with path
// compression kept alongside the run, or against the result given in the
// directed table. A short table of directed operations comes first. Random
// traffic follows, under several node limits, with bursty sending and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench
  import dsu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Result of an operation on a node outside the limit.
  localparam dsu_res_t REJECTED = '{root: '0, comp_size: '0, merged: 1'b0, error: 1'b1};

  // Receiver ready patterns; the receiver switches between them at random.
  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_MOSTLY, RX_SLOW} rx_mode_t;

  // One line of the directed table: a register write or an operation.
  typedef struct {
    bit               is_cfg;
    logic [CFG_W-1:0] cfg_value;
    logic             func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    bit               typed;
    dsu_res_t         want;
  } op_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  dsu_in_if  in_chan();
  dsu_out_if out_chan();

  disjoint_set_union_by_size dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Predicted forest: parent links, set sizes at the roots, node limit.
  logic [NODE_W-1:0] uf_parent [NODES_DEF];
  int unsigned       uf_size [NODES_DEF];
  logic [CFG_W-1:0]  uf_node_count;

  dsu_res_t    expected_results[$];
  op_row_t     directed_ops[$];
  int unsigned fail_count = 0;
  int unsigned ops_sent = 0;
  int unsigned results_checked = 0;
  int unsigned sets_joined = 0;
  int unsigned ops_rejected = 0;
  int unsigned largest_set = 1;
  int unsigned burst_left = 0;

  // Walk to the root, then relink every node on the path straight to it.
  function automatic int unsigned find_and_compress(int unsigned x);
    int unsigned r;
    int unsigned nxt;
    int unsigned steps;
    r = x;
    steps = 0;
    while (uf_parent[r] != r && steps < NODES_DEF) begin
      r = uf_parent[r];
      steps++;
    end
    steps = 0;
    while (x != r && steps < NODES_DEF) begin
      nxt = uf_parent[x];
      uf_parent[x] = r[NODE_W-1:0];
      x = nxt;
      steps++;
    end
    return r;
  endfunction

  // Apply one operation to the predicted forest and return its result.
  function automatic dsu_res_t union_find_step(logic func, logic [NODE_W-1:0] a,
                                               logic [NODE_W-1:0] b);
    int unsigned lim;
    int unsigned ra;
    int unsigned rb;
    int unsigned sz;
    dsu_res_t    res;
    lim = (uf_node_count < NODES_DEF) ? uf_node_count : NODES_DEF;
    if (a >= lim || (func == FUNC_MERGE && b >= lim)) begin
      ops_rejected++;
      return REJECTED;
    end
    res = '0;
    ra = find_and_compress(a);
    if (func == FUNC_MERGE) begin
      rb = find_and_compress(b);
      if (ra != rb) begin
        if (uf_size[ra] >= uf_size[rb]) begin
          uf_parent[rb] = ra[NODE_W-1:0];
          uf_size[ra] += uf_size[rb];
        end else begin
          uf_parent[ra] = rb[NODE_W-1:0];
          uf_size[rb] += uf_size[ra];
          ra = rb;
        end
        res.merged = 1'b1;
        sets_joined++;
      end
    end
    sz = uf_size[ra];
    if (sz > largest_set) largest_set = sz;
    if (sz > SIZE_MAX) sz = SIZE_MAX;
    res.root = ra[NODE_W-1:0];
    res.comp_size = sz[SIZE_W-1:0];
    return res;
  endfunction

  function automatic dsu_res_t res_of(int unsigned root, int unsigned size, bit merged);
    dsu_res_t r;
    r = '0;
    r.root = root[NODE_W-1:0];
    r.comp_size = size[SIZE_W-1:0];
    r.merged = merged;
    return r;
  endfunction

  // Table builders.
  function automatic void row_op(logic func, int unsigned a, int unsigned b);
    op_row_t row;
    row = '{is_cfg: 1'b0, cfg_value: '0, func: func, node_a: a[NODE_W-1:0],
            node_b: b[NODE_W-1:0], typed: 1'b0, want: '0};
    directed_ops.push_back(row);
  endfunction

  function automatic void row_chk(logic func, int unsigned a, int unsigned b, dsu_res_t want);
    op_row_t row;
    row = '{is_cfg: 1'b0, cfg_value: '0, func: func, node_a: a[NODE_W-1:0],
            node_b: b[NODE_W-1:0], typed: 1'b1, want: want};
    directed_ops.push_back(row);
  endfunction

  function automatic void row_cfg(int unsigned value);
    op_row_t row;
    row = '{is_cfg: 1'b1, cfg_value: value[CFG_W-1:0], func: FUNC_QUERY, node_a: '0,
            node_b: '0, typed: 1'b0, want: '0};
    directed_ops.push_back(row);
  endfunction

  // Present one operation and hold it until the engine takes it.
  task automatic send_op(logic func, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                         bit typed, dsu_res_t want);
    dsu_res_t predicted;
    @(negedge clk);
    in_chan.valid  <= 1'b1;
    in_chan.func   <= func;
    in_chan.node_a <= a;
    in_chan.node_b <= b;
    do @(posedge clk); while (!in_chan.ready);
    predicted = union_find_step(func, a, b);
    expected_results.push_back(typed ? want : predicted);
    ops_sent++;
  endtask

  // Sender pacing: bursts of transfers separated by idle gaps.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 16);
    gap = $urandom_range(1, 6);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // Stop sending and wait until every outstanding result has been seen.
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Change the node limit with the engine idle.
  task automatic set_node_count(logic [CFG_W-1:0] value);
    drain_results();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    uf_node_count = value;
  endtask

  // Random operation, mostly on nodes inside the limit.
  task automatic send_random_op();
    int unsigned lim;
    logic        func;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    lim = (uf_node_count < NODES_DEF) ? uf_node_count : NODES_DEF;
    func = ($urandom_range(0, 99) < 60) ? FUNC_MERGE : FUNC_QUERY;
    a = NODE_W'((($urandom_range(0, 99) < 8) || (lim == 0)) ?
                $urandom_range(0, NODES_DEF - 1) : $urandom_range(0, lim - 1));
    if (func == FUNC_QUERY)
      b = NODE_W'($urandom());
    else
      b = NODE_W'((($urandom_range(0, 99) < 8) || (lim == 0)) ?
                  $urandom_range(0, NODES_DEF - 1) : $urandom_range(0, lim - 1));
    send_op(func, a, b, 1'b0, '0);
  endtask

  // Receiver: ready follows a pattern that changes mode every so often.
  initial begin
    rx_mode_t    mode;
    int unsigned phase_cnt;
    out_chan.ready = 1'b0;
    phase_cnt = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(20, 120)) begin
        @(negedge clk);
        phase_cnt++;
        case (mode)
          RX_STEADY: out_chan.ready <= 1'b1;
          RX_COIN:   out_chan.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_chan.ready <= ($urandom_range(0, 7) != 0);
          default:   out_chan.ready <= (phase_cnt % 11) < 3;
        endcase
      end
    end
  end

  // Compare each transferred result with the oldest expectation.
  always @(posedge clk) begin
    dsu_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transferred with none expected: root %0d size %0d",
               out_chan.root, out_chan.comp_size);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_chan.root !== want.root) begin
          $error("root: expected %0d, got %0d", want.root, out_chan.root);
          fail_count++;
        end
        if (out_chan.comp_size !== want.comp_size) begin
          $error("comp_size: expected %0d, got %0d", want.comp_size, out_chan.comp_size);
          fail_count++;
        end
        if (out_chan.merged !== want.merged) begin
          $error("merged: expected %0b, got %0b", want.merged, out_chan.merged);
          fail_count++;
        end
        if (out_chan.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_chan.error);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int unsigned limits[$];
    in_chan.valid  = 1'b0;
    in_chan.func   = FUNC_QUERY;
    in_chan.node_a = '0;
    in_chan.node_b = '0;
    for (int i = 0; i < NODES_DEF; i++) begin
      uf_parent[i] = i[NODE_W-1:0];
      uf_size[i] = 1;
    end
    uf_node_count = CFG_RESET;

    // Fresh forest at the full limit: extremes, ties, chains, self merges.
    row_chk(FUNC_QUERY, 0, 0, res_of(0, 1, 0));
    row_chk(FUNC_QUERY, 1023, 1023, res_of(1023, 1, 0));
    row_chk(FUNC_MERGE, 0, 1023, res_of(0, 2, 1));
    row_chk(FUNC_MERGE, 1023, 0, res_of(0, 2, 0));
    row_chk(FUNC_MERGE, 5, 6, res_of(5, 2, 1));
    row_op(FUNC_MERGE, 7, 5);
    row_op(FUNC_MERGE, 6, 0);
    row_chk(FUNC_MERGE, 1000, 3, res_of(1000, 2, 1));
    row_op(FUNC_MERGE, 9, 8);
    row_op(FUNC_MERGE, 10, 11);
    row_op(FUNC_MERGE, 9, 10);
    row_op(FUNC_MERGE, 12, 9);
    row_op(FUNC_QUERY, 11, 682);
    row_op(FUNC_MERGE, 1023, 1023);
    // Lowered limit: rejections on either node, and a root above the limit.
    row_cfg(16);
    row_chk(FUNC_QUERY, 15, 0, res_of(15, 1, 0));
    row_chk(FUNC_QUERY, 16, 0, REJECTED);
    row_chk(FUNC_MERGE, 3, 16, REJECTED);
    row_chk(FUNC_MERGE, 16, 3, REJECTED);
    row_chk(FUNC_QUERY, 1023, 1023, REJECTED);
    row_op(FUNC_QUERY, 3, 1023);
    row_op(FUNC_MERGE, 0, 2);
    // Smallest limits, zero rejecting every node.
    row_cfg(1);
    row_op(FUNC_QUERY, 0, 0);
    row_chk(FUNC_QUERY, 1, 0, REJECTED);
    row_op(FUNC_MERGE, 0, 0);
    row_cfg(0);
    row_chk(FUNC_QUERY, 0, 0, REJECTED);
    row_chk(FUNC_MERGE, 0, 0, REJECTED);
    // Register above the store size is clamped to it.
    row_cfg(2047);
    row_op(FUNC_QUERY, 1023, 341);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) begin
      if (directed_ops[i].is_cfg) begin
        set_node_count(directed_ops[i].cfg_value);
      end else begin
        send_op(directed_ops[i].func, directed_ops[i].node_a, directed_ops[i].node_b,
                directed_ops[i].typed, directed_ops[i].want);
        pace_sender();
      end
    end

    // Random phases: small limits merge the low nodes densely, larger limits join them to the rest.
    limits = '{1024, 8, 64, 1024, 3, 300, 2047, 512, 1024};
    foreach (limits[p]) begin
      set_node_count(CFG_W'(limits[p]));
      repeat (155) begin
        send_random_op();
        pace_sender();
        if ($urandom_range(0, 299) == 0) drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Covered %0d operations: %0d joins, %0d rejected, largest set %0d.",
             ops_sent, sets_joined, ops_rejected, largest_set);
    $display("Checked %0d results under node limits from 0 to 2047.", results_checked);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/dsu_pkg.sv
sv/dsu_if.sv
sv/dsu_engine.sv
sv/disjoint_set_union_by_size.sv
tb/sv/testbench.sv
